@@ sv/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types, codes and constants of the pure pursuit path tracker.
// ----------------------------------------------------------------------------
package ppt_pkg;

	// Result status codes.
	localparam logic [2:0] STATUS_DRIVE    = 3'd0;
	localparam logic [2:0] STATUS_DEADMAN  = 3'd1;
	localparam logic [2:0] STATUS_EMPTY    = 3'd2;
	localparam logic [2:0] STATUS_NO_LOOK  = 3'd3;
	localparam logic [2:0] STATUS_WR_DONE  = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] CFG_LOOKAHEAD   = 3'd0;
	localparam logic [2:0] CFG_AXLE        = 3'd1;
	localparam logic [2:0] CFG_STEER_LIMIT = 3'd2;
	localparam logic [2:0] CFG_FIXED_EN    = 3'd3;
	localparam logic [2:0] CFG_FIXED_SPEED = 3'd4;
	localparam logic [2:0] CFG_PATH_LEN    = 3'd5;

	// Reciprocal of the CORDIC gain, Q30.
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic [3:0]  LAST_STEP    = 4'd15;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [12:0]        spd;
	} wp_t;

	typedef struct packed {
		logic hit;
		wp_t  tgt;
	} scan_res_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_NEAR_GO,
		T_NEAR,
		T_LOOK_GO,
		T_LOOK,
		T_STEER_GO,
		T_STEER
	} top_state_t;

	typedef enum logic [3:0] {
		SS_IDLE,
		SS_QSUM,
		SS_ROT,
		SS_GMUL,
		SS_GSUM,
		SS_NMUL,
		SS_NSUM,
		SS_ATAN,
		SS_OUT
	} steer_state_t;

	// Arctangent of 2^-i in Q16 radians.
	function automatic logic [16:0] atan_q16(input logic [3:0] i);
		logic [16:0] v;
		unique case (i)
			4'd0:  v = 17'd51472;
			4'd1:  v = 17'd30386;
			4'd2:  v = 17'd16055;
			4'd3:  v = 17'd8150;
			4'd4:  v = 17'd4091;
			4'd5:  v = 17'd2047;
			4'd6:  v = 17'd1024;
			4'd7:  v = 17'd512;
			4'd8:  v = 17'd256;
			4'd9:  v = 17'd128;
			4'd10: v = 17'd64;
			4'd11: v = 17'd32;
			4'd12: v = 17'd16;
			4'd13: v = 17'd8;
			4'd14: v = 17'd4;
			4'd15: v = 17'd2;
		endcase
		return v;
	endfunction

endpackage

@@ sv/ppt_path_mem.sv @@
// ----------------------------------------------------------------------------
// ppt_path_mem
// Waypoint store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppt_path_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  ppt_pkg::wp_t  wdata,
	input  logic [AW-1:0] raddr,
	output ppt_pkg::wp_t  rdata
);

	ppt_pkg::wp_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ sv/ppt_scan.sv @@
// ----------------------------------------------------------------------------
// ppt_scan
// Pipelined path scan: issues one read a cycle around the closed path and
// compares squared distances, for the nearest point or the lookahead point.
// ----------------------------------------------------------------------------
module ppt_scan #(
	parameter int AW = 10,
	parameter int CW = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                look,
	input  logic [AW-1:0]       first_idx,
	input  logic [CW-1:0]       count,
	input  logic [CW-1:0]       n,
	input  logic signed [31:0]  vx,
	input  logic signed [31:0]  vy,
	input  logic [41:0]         ld2,
	output logic [AW-1:0]       rd_addr,
	input  ppt_pkg::wp_t        rd_data,
	output logic                done,
	output logic [AW-1:0]       best,
	output ppt_pkg::scan_res_t  res
);

	logic run_q, iss_act_q, first_q, done_q;
	logic [AW-1:0] iss_idx_q, best_q;
	logic [CW-1:0] iss_left_q;
	logic [63:0] bestd_q;
	ppt_pkg::scan_res_t res_q;

	logic v_s1, v_s2, v_s3;
	logic last_s1, last_s2, last_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	ppt_pkg::wp_t wp_s2, wp_s3;
	logic [31:0] ux_s2, uy_s2;
	logic [63:0] sx_s3, sy_s3;

	logic signed [32:0] dx, dy;
	logic [64:0] sum;
	logic [63:0] d;
	logic fin, take_best, take_hit;
	logic [AW-1:0] idx_next;

	assign rd_addr = iss_idx_q;
	assign idx_next = ((CW'(iss_idx_q) + CW'(1)) == n) ? '0 : iss_idx_q + AW'(1);

	assign dx = 33'(rd_data.x) - 33'(vx);
	assign dy = 33'(rd_data.y) - 33'(vy);

	assign sum = {1'b0, sx_s3} + {1'b0, sy_s3};
	assign d   = sum[64] ? '1 : sum[63:0];

	always_comb begin
		fin       = 1'b0;
		take_best = 1'b0;
		take_hit  = 1'b0;
		if (v_s3) begin
			if (!look) begin
				// The first point seeds the minimum; ties move on, a rise ends it.
				if (first_q || d <= bestd_q) begin
					take_best = 1'b1;
					fin       = last_s3;
				end else begin
					fin = 1'b1;
				end
			end else begin
				if (d >= {22'd0, ld2}) begin
					take_hit = 1'b1;
					fin      = 1'b1;
				end else begin
					fin = last_s3;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			iss_act_q <= 1'b0;
			first_q   <= 1'b0;
			done_q    <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			iss_idx_q <= '0;
			iss_left_q <= '0;
			best_q    <= '0;
			bestd_q   <= '0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q      <= (count != '0);
				iss_act_q  <= (count != '0);
				iss_idx_q  <= first_idx;
				iss_left_q <= count;
				first_q    <= 1'b1;
				v_s1       <= 1'b0;
				v_s2       <= 1'b0;
				v_s3       <= 1'b0;
				res_q.hit  <= 1'b0;
				if (count == '0) begin
					done_q <= 1'b1;
				end
			end else if (run_q) begin
				if (take_best) begin
					best_q  <= idx_s3;
					bestd_q <= d;
					first_q <= 1'b0;
				end
				if (take_hit) begin
					res_q <= {1'b1, wp_s3};
				end
				if (fin) begin
					// Reads already in flight are dropped.
					run_q     <= 1'b0;
					iss_act_q <= 1'b0;
					v_s1      <= 1'b0;
					v_s2      <= 1'b0;
					v_s3      <= 1'b0;
					done_q    <= 1'b1;
				end else begin
					v_s1 <= iss_act_q;
					v_s2 <= v_s1;
					v_s3 <= v_s2;
					if (iss_act_q) begin
						iss_idx_q  <= idx_next;
						iss_left_q <= iss_left_q - CW'(1);
						if (iss_left_q == CW'(1)) begin
							iss_act_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= iss_idx_q;
		last_s1 <= (iss_left_q == CW'(1));
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		wp_s2   <= rd_data;
		ux_s2   <= dx[32] ? 32'(-dx) : dx[31:0];
		uy_s2   <= dy[32] ? 32'(-dy) : dy[31:0];
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		wp_s3   <= wp_s2;
		sx_s3   <= ux_s2 * ux_s2;
		sy_s3   <= uy_s2 * uy_s2;
	end

	assign done = done_q;
	assign best = best_q;
	assign res  = res_q;

	ap_fin_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> run_q)
		else $error("scan finished while not running");
	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q || $past(start))
		else $error("scan done held for two cycles");
	ap_stage_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> !v_s1 && !v_s2 && !v_s3)
		else $error("pipeline stage valid while scan idle");

endmodule

@@ sv/ppt_steer.sv @@
// ----------------------------------------------------------------------------
// ppt_steer
// Steering unit: quaternion yaw, CORDIC rotation of the target point, gain
// correction, then CORDIC arctangent and clamp. One step per cycle.
// ----------------------------------------------------------------------------
module ppt_steer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [15:0] qx,
	input  logic signed [15:0] qy,
	input  logic signed [15:0] qz,
	input  logic signed [15:0] qw,
	input  logic signed [31:0] shift_y,
	input  logic [17:0]        axle,
	input  logic [41:0]        ld2,
	input  logic [13:0]        steer_limit,
	output logic               done,
	output logic signed [14:0] steer
);

	ppt_pkg::steer_state_t state_q, state_d;
	logic [3:0] iter_q;
	logic a_zero_q;

	logic signed [31:0] pwz_q, pxy_q, pyy_q, pzz_q;
	logic signed [35:0] ca_q, cb_q, cx_q, cy_q;
	logic signed [48:0] ph_q;
	logic [47:0]        pl_q;
	logic signed [37:0] yl_q;
	logic signed [37:0] nh_q;
	logic [36:0]        nl_q;
	logic signed [59:0] ax_q, ay_q;
	logic signed [17:0] az_q;

	logic signed [35:0] a_c, b_c;
	logic signed [67:0] prod_c;
	logic signed [37:0] rot_c;
	logic signed [57:0] num_c;
	logic signed [17:0] ang_c, lim_c, atan_c;

	assign a_c    = (36'(pwz_q) + 36'(pxy_q)) <<< 1;
	assign b_c    = 36'sd268435456 - ((36'(pyy_q) + 36'(pzz_q)) <<< 1);
	assign prod_c = (68'(ph_q) <<< 18) + $signed({20'd0, pl_q});
	assign rot_c  = a_zero_q ? 38'(cy_q) : 38'(prod_c >>> 30);
	assign num_c  = ((58'(nh_q) <<< 19) + $signed({21'd0, nl_q})) <<< 1;
	assign atan_c = $signed({1'b0, ppt_pkg::atan_q16(iter_q)});
	assign ang_c  = (az_q + 18'sd4) >>> 3;
	assign lim_c  = $signed({4'd0, steer_limit});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppt_pkg::SS_IDLE: if (start) state_d = ppt_pkg::SS_QSUM;
			ppt_pkg::SS_QSUM: state_d = (a_c == '0) ? ppt_pkg::SS_GSUM : ppt_pkg::SS_ROT;
			ppt_pkg::SS_ROT:  if (iter_q == ppt_pkg::LAST_STEP) state_d = ppt_pkg::SS_GMUL;
			ppt_pkg::SS_GMUL: state_d = ppt_pkg::SS_GSUM;
			ppt_pkg::SS_GSUM: state_d = ppt_pkg::SS_NMUL;
			ppt_pkg::SS_NMUL: state_d = ppt_pkg::SS_NSUM;
			ppt_pkg::SS_NSUM: state_d = (num_c == '0) ? ppt_pkg::SS_OUT : ppt_pkg::SS_ATAN;
			ppt_pkg::SS_ATAN: if (iter_q == ppt_pkg::LAST_STEP) state_d = ppt_pkg::SS_OUT;
			ppt_pkg::SS_OUT:  state_d = ppt_pkg::SS_IDLE;
			default:          state_d = ppt_pkg::SS_IDLE;
		endcase
	end

	always_comb begin
		done  = (state_q == ppt_pkg::SS_OUT);
		steer = '0;
		if (ang_c > lim_c) begin
			steer = lim_c[14:0];
		end else if (ang_c < -lim_c) begin
			steer = 15'(-lim_c);
		end else begin
			steer = ang_c[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppt_pkg::SS_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ppt_pkg::SS_ROT || state_q == ppt_pkg::SS_ATAN) begin
				iter_q <= iter_q + 4'd1;
			end else begin
				iter_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ppt_pkg::SS_IDLE: begin
				pwz_q <= qw * qz;
				pxy_q <= qx * qy;
				pyy_q <= qy * qy;
				pzz_q <= qz * qz;
				cx_q  <= 36'(px);
				cy_q  <= 36'(py);
			end
			ppt_pkg::SS_QSUM: begin
				a_zero_q <= (a_c == '0);
				// A negative cosine term means a half turn first.
				if (b_c < 0) begin
					ca_q <= -a_c;
					cb_q <= -b_c;
					cx_q <= -cx_q;
					cy_q <= -cy_q;
				end else begin
					ca_q <= a_c;
					cb_q <= b_c;
				end
			end
			ppt_pkg::SS_ROT: begin
				if (!ca_q[35]) begin
					cb_q <= cb_q + (ca_q >>> iter_q);
					ca_q <= ca_q - (cb_q >>> iter_q);
					cx_q <= cx_q - (cy_q >>> iter_q);
					cy_q <= cy_q + (cx_q >>> iter_q);
				end else begin
					cb_q <= cb_q - (ca_q >>> iter_q);
					ca_q <= ca_q + (cb_q >>> iter_q);
					cx_q <= cx_q + (cy_q >>> iter_q);
					cy_q <= cy_q - (cx_q >>> iter_q);
				end
			end
			ppt_pkg::SS_GMUL: begin
				ph_q <= $signed(cy_q[35:18]) * $signed({1'b0, ppt_pkg::INV_GAIN_Q30});
				pl_q <= cy_q[17:0] * ppt_pkg::INV_GAIN_Q30;
			end
			ppt_pkg::SS_GSUM: begin
				yl_q <= rot_c + 38'(shift_y);
			end
			ppt_pkg::SS_NMUL: begin
				nh_q <= $signed(yl_q[37:19]) * $signed({1'b0, axle});
				nl_q <= yl_q[18:0] * axle;
			end
			ppt_pkg::SS_NSUM: begin
				ax_q <= $signed({18'd0, ld2});
				ay_q <= 60'(num_c);
				az_q <= '0;
			end
			ppt_pkg::SS_ATAN: begin
				if (!ay_q[59]) begin
					ax_q <= ax_q + (ay_q >>> iter_q);
					ay_q <= ay_q - (ax_q >>> iter_q);
					az_q <= az_q + atan_c;
				end else begin
					ax_q <= ax_q - (ay_q >>> iter_q);
					ay_q <= ay_q + (ax_q >>> iter_q);
					az_q <= az_q - atan_c;
				end
			end
			ppt_pkg::SS_OUT: begin
			end
			default: begin
			end
		endcase
	end

	ap_rot_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ppt_pkg::SS_GMUL |-> $past(iter_q) == ppt_pkg::LAST_STEP)
		else $error("rotation left before its last step");
	ap_steer_lim: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 18'(steer) <= lim_c && -18'(steer) <= lim_c)
		else $error("steering outside the limit");
	ap_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ppt_pkg::SS_IDLE)
		else $error("steering unit started while busy");

endmodule

@@ sv/pure_pursuit_path_tracker.sv @@
// ----------------------------------------------------------------------------
// pure_pursuit_path_tracker
// Pure pursuit steering over a closed waypoint path held in on-chip memory.
// ----------------------------------------------------------------------------
//  Channel   Signals                                         Transfer
//  command   start, busy, operation .. quat_w                start & !busy
//  config    cfg_we, cfg_index, cfg_data                     cfg_we
//  result    done, steer_cmd, speed_cmd, status, nearest_slot done (1 cycle)
//
// A waypoint write, a dead-man stop or an empty path gives its result in the
// cycle after the transfer. A driving tick runs two pipelined scans of the
// waypoint memory, one read a cycle, then, if a lookahead point is found,
// 16 rotation and 16 arctangent steps in the steering unit.
// Reset clears the control state and loads the default configuration;
// waypoints are undefined until written. The result has no back pressure.
module pure_pursuit_path_tracker #(
	parameter int MAX_WAYPOINTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [9:0]         waypoint_slot,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [12:0]        waypoint_speed,
	input  logic               dead_man,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [20:0]        cfg_data,
	output logic               done,
	output logic signed [14:0] steer_cmd,
	output logic [12:0]        speed_cmd,
	output logic [2:0]         status,
	output logic [9:0]         nearest_slot
);

	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int LW = (CW > 11) ? CW : 11;
	localparam int XW = (AW > 10) ? AW : 10;

	ppt_pkg::top_state_t state_q, state_d;

	logic [20:0] lookahead_q;
	logic [17:0] axle_q;
	logic [13:0] steer_limit_q;
	logic        fixed_en_q;
	logic [12:0] fixed_speed_q;
	logic [10:0] path_len_q;

	logic [AW-1:0]      cache_q;
	logic signed [31:0] vx_q, vy_q, shift_y_q;
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic [41:0]        ld2_q;
	logic [12:0]        spd_q;

	logic               done_q;
	logic signed [14:0] steer_q;
	logic [12:0]        speed_q;
	logic [2:0]         status_q;
	logic [9:0]         slot_q;

	logic acc, mem_we, slot_ok;
	logic [LW-1:0] plen;
	logic [CW-1:0] n_c;
	logic [AW-1:0] c_c, look_first;
	logic [XW-1:0] slot_ext, best_ext;

	logic          scan_start, scan_look, scan_done;
	logic [AW-1:0] scan_first, rd_addr, best_w;
	logic [CW-1:0] scan_count;
	ppt_pkg::wp_t  rd_data, wr_data;
	ppt_pkg::scan_res_t scan_res;

	logic               steer_start, steer_done;
	logic signed [14:0] steer_w;

	assign acc      = start && !busy;
	assign slot_ext = XW'(waypoint_slot);
	assign slot_ok  = {22'd0, waypoint_slot} < 32'(MAX_WAYPOINTS);
	assign mem_we   = acc && !operation && slot_ok;
	assign wr_data  = '{x: pos_x, y: pos_y, spd: waypoint_speed};

	assign plen = LW'(path_len_q);
	assign n_c  = (plen < LW'(MAX_WAYPOINTS)) ? CW'(plen) : CW'(MAX_WAYPOINTS);
	// A cached index past the end of a shortened path restarts at zero.
	assign c_c  = (CW'(cache_q) < n_c) ? cache_q : '0;
	assign look_first = ((CW'(best_w) + CW'(1)) == n_c) ? '0 : best_w + AW'(1);
	assign best_ext   = XW'(best_w);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppt_pkg::T_IDLE:
				if (acc && operation && dead_man && n_c != '0) state_d = ppt_pkg::T_NEAR_GO;
			ppt_pkg::T_NEAR_GO:  state_d = ppt_pkg::T_NEAR;
			ppt_pkg::T_NEAR:     if (scan_done) state_d = ppt_pkg::T_LOOK_GO;
			ppt_pkg::T_LOOK_GO:  state_d = ppt_pkg::T_LOOK;
			ppt_pkg::T_LOOK:
				if (scan_done) state_d = scan_res.hit ? ppt_pkg::T_STEER_GO : ppt_pkg::T_IDLE;
			ppt_pkg::T_STEER_GO: state_d = ppt_pkg::T_STEER;
			ppt_pkg::T_STEER:    if (steer_done) state_d = ppt_pkg::T_IDLE;
			default:             state_d = ppt_pkg::T_IDLE;
		endcase
	end

	always_comb begin
		busy        = (state_q != ppt_pkg::T_IDLE);
		scan_start  = (state_q == ppt_pkg::T_NEAR_GO) || (state_q == ppt_pkg::T_LOOK_GO);
		scan_look   = (state_q == ppt_pkg::T_LOOK_GO) || (state_q == ppt_pkg::T_LOOK);
		scan_first  = scan_look ? look_first : c_c;
		scan_count  = scan_look ? n_c - CW'(1) : n_c;
		steer_start = (state_q == ppt_pkg::T_STEER_GO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ppt_pkg::T_IDLE;
			cache_q       <= '0;
			done_q        <= 1'b0;
			lookahead_q   <= 21'd9830;
			axle_q        <= 18'd20316;
			steer_limit_q <= 14'd4260;
			fixed_en_q    <= 1'b1;
			fixed_speed_q <= 13'd128;
			path_len_q    <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					ppt_pkg::CFG_LOOKAHEAD:   lookahead_q   <= cfg_data;
					ppt_pkg::CFG_AXLE:        axle_q        <= cfg_data[17:0];
					ppt_pkg::CFG_STEER_LIMIT: steer_limit_q <= cfg_data[13:0];
					ppt_pkg::CFG_FIXED_EN:    fixed_en_q    <= cfg_data[0];
					ppt_pkg::CFG_FIXED_SPEED: fixed_speed_q <= cfg_data[12:0];
					ppt_pkg::CFG_PATH_LEN:    path_len_q    <= cfg_data[10:0];
					default: begin
					end
				endcase
			end
			if (acc && (!operation || !dead_man || n_c == '0)) begin
				done_q <= 1'b1;
			end
			if (state_q == ppt_pkg::T_NEAR && scan_done) begin
				cache_q <= best_w;
			end
			if (state_q == ppt_pkg::T_LOOK && scan_done && !scan_res.hit) begin
				done_q <= 1'b1;
			end
			if (state_q == ppt_pkg::T_STEER && steer_done) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			vx_q      <= pos_x;
			vy_q      <= pos_y;
			shift_y_q <= shift_y;
			qx_q      <= quat_x;
			qy_q      <= quat_y;
			qz_q      <= quat_z;
			qw_q      <= quat_w;
			ld2_q     <= lookahead_q * lookahead_q;
			steer_q   <= '0;
			speed_q   <= '0;
			slot_q    <= '0;
			if (!operation) begin
				status_q <= ppt_pkg::STATUS_WR_DONE;
			end else if (!dead_man) begin
				status_q <= ppt_pkg::STATUS_DEADMAN;
			end else begin
				status_q <= ppt_pkg::STATUS_EMPTY;
			end
		end
		if (state_q == ppt_pkg::T_LOOK && scan_done) begin
			spd_q    <= fixed_en_q ? fixed_speed_q : scan_res.tgt.spd;
			status_q <= ppt_pkg::STATUS_NO_LOOK;
			slot_q   <= best_ext[9:0];
		end
		if (state_q == ppt_pkg::T_STEER && steer_done) begin
			steer_q  <= steer_w;
			speed_q  <= spd_q;
			status_q <= ppt_pkg::STATUS_DRIVE;
		end
	end

	// Writes happen only while idle and read data is used only during a tick,
	// so no write can collide with a read whose data is used.
	ppt_path_mem #(
		.DEPTH (MAX_WAYPOINTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_ext[AW-1:0]),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ppt_scan #(
		.AW (AW),
		.CW (CW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.look      (scan_look),
		.first_idx (scan_first),
		.count     (scan_count),
		.n         (n_c),
		.vx        (vx_q),
		.vy        (vy_q),
		.ld2       (ld2_q),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.done      (scan_done),
		.best      (best_w),
		.res       (scan_res)
	);

	ppt_steer u_steer (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (steer_start),
		.px          (scan_res.tgt.x),
		.py          (scan_res.tgt.y),
		.qx          (qx_q),
		.qy          (qy_q),
		.qz          (qz_q),
		.qw          (qw_q),
		.shift_y     (shift_y_q),
		.axle        (axle_q),
		.ld2         (ld2_q),
		.steer_limit (steer_limit_q),
		.done        (steer_done),
		.steer       (steer_w)
	);

	assign done         = done_q;
	assign steer_cmd    = steer_q;
	assign speed_cmd    = speed_q;
	assign status       = status_q;
	assign nearest_slot = slot_q;

	ap_scan_state: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> state_q == ppt_pkg::T_NEAR || state_q == ppt_pkg::T_LOOK)
		else $error("scan completion outside a scan state");
	ap_steer_state: assert property (@(posedge clk) disable iff (!arst_n)
		steer_done |-> state_q == ppt_pkg::T_STEER)
		else $error("steering completion outside the steering state");
	ap_cache_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ppt_pkg::T_LOOK_GO |-> CW'(cache_q) < n_c)
		else $error("nearest index outside the path");
	ap_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ppt_pkg::T_IDLE)
		else $error("waypoint write during a tick");

endmodule
